FILE: hdl/atbb_pkg.sv
// Shared types and constants for the alpha trim bounding box unit.
// No dependencies; every other file in the project imports this package.
package atbb_pkg;

  localparam int unsigned MAX_SIDE_DEF = 4096;

  localparam int unsigned ALPHA_W    = 8;
  localparam int unsigned SIDE_CFG_W = 13;
  localparam int unsigned RECT_W     = 13;
  localparam int unsigned CFG_DATA_W = 13;
  localparam int unsigned CFG_IDX_W  = 2;

  localparam logic [ALPHA_W-1:0]    THRESH_RST = 8'd0;
  localparam logic [SIDE_CFG_W-1:0] SIDE_RST   = 13'd4096;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ALPHA_THRESHOLD = 2'd0,
    CFG_FRAME_WIDTH     = 2'd1,
    CFG_FRAME_HEIGHT    = 2'd2
  } cfg_idx_t;

  // Control for one extent tracker (column axis or row axis).
  typedef struct packed {
    logic upd;    // an opaque pixel is retired this cycle
    logic first;  // no opaque pixel seen yet in this frame
    logic clear;  // frame closes this cycle
  } atbb_axis_ctl_t;

endpackage

FILE: hdl/atbb_if.sv
// Valid/ready channel interfaces: pixel words in, trim rectangle words out.
// Depends on atbb_pkg for field widths.
interface atbb_pix_if;
  import atbb_pkg::*;
  logic               valid;
  logic               ready;
  logic [ALPHA_W-1:0] alpha;
  modport source (output valid, output alpha, input ready);
  modport sink (input valid, input alpha, output ready);
endinterface

interface atbb_rect_if;
  import atbb_pkg::*;
  logic              valid;
  logic              ready;
  logic [RECT_W-1:0] rect_x;
  logic [RECT_W-1:0] rect_y;
  logic [RECT_W-1:0] rect_w;
  logic [RECT_W-1:0] rect_h;
  modport source (output valid, output rect_x, output rect_y, output rect_w, output rect_h,
                  input ready);
  modport sink (input valid, input rect_x, input rect_y, input rect_w, input rect_h,
                output ready);
endinterface

FILE: hdl/alpha_trim_bounding_box_unit.sv
// Top level of the alpha trim bounding box unit.
// Depends on atbb_pkg, the channel interfaces in atbb_if.sv and atbb_axis.
//
// Usage: alpha words of one frame arrive in raster order on in_pix, one word per
// accepted handshake. A pixel is opaque when its alpha is strictly above the
// threshold register. On the last pixel of each frame the unit sends one word on
// out_rect holding the trim rectangle (x, y, width, height); an empty frame gives
// x = frame width, y = frame height and zero size. No other pixel produces a word.
// Throughput is one pixel per clock unless a frame ends while a result waits. An
// accepted pixel is held in an input register and then retired into the position
// counters and extent trackers; the rectangle is loaded into the result register
// when the last pixel retires. When the receiver stalls, the result register holds its word; only a
// frame's last pixel waits in the input register for that word to leave, so the
// input backs up by at most one word. Reset clears the channels, restores the
// configuration to threshold 0 and a 4096 by 4096 frame, and starts a new frame.
// Configuration writes on cfg_we/cfg_idx/cfg_wdata take effect at once and are
// meant to be made between frames; an unknown index is ignored.
module alpha_trim_bounding_box_unit #(
  parameter int unsigned MAX_SIDE = atbb_pkg::MAX_SIDE_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  atbb_pix_if.sink                           in_pix,
  atbb_rect_if.source                        out_rect,
  input  logic                               cfg_we,
  input  logic [atbb_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  logic [atbb_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import atbb_pkg::*;

  // Position width covers 0..MAX_SIDE-1; side width covers 1..MAX_SIDE.
  localparam int unsigned POS_W  = $clog2(MAX_SIDE);
  localparam int unsigned SIDE_W = $clog2(MAX_SIDE + 1);
  localparam int unsigned CMP_W  = (SIDE_W > SIDE_CFG_W) ? SIDE_W : SIDE_CFG_W;
  localparam logic [CMP_W-1:0] MAX_SIDE_C = CMP_W'(MAX_SIDE);
  localparam logic [POS_W-1:0] POS_LO_RST = POS_W'(MAX_SIDE - 1);

  // Configuration registers.
  logic [ALPHA_W-1:0]    thr_r;
  logic [SIDE_CFG_W-1:0] width_r, height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r    <= THRESH_RST;
      width_r  <= SIDE_RST;
      height_r <= SIDE_RST;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_idx))
        CFG_ALPHA_THRESHOLD: thr_r    <= cfg_wdata[ALPHA_W-1:0];
        CFG_FRAME_WIDTH:     width_r  <= cfg_wdata[SIDE_CFG_W-1:0];
        CFG_FRAME_HEIGHT:    height_r <= cfg_wdata[SIDE_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // A zero size is taken as one and a size above MAX_SIDE as MAX_SIDE.
  function automatic logic [CMP_W-1:0] clamp_side(input logic [SIDE_CFG_W-1:0] v);
    logic [CMP_W-1:0] ext;
    logic [CMP_W-1:0] res;
    ext = CMP_W'(v);
    res = ext;
    if (ext == '0) begin
      res = CMP_W'(1);
    end else if (ext > MAX_SIDE_C) begin
      res = MAX_SIDE_C;
    end
    return res;
  endfunction

  logic [CMP_W-1:0] w_eff, h_eff;
  assign w_eff = clamp_side(width_r);
  assign h_eff = clamp_side(height_r);

  // Input stage: one pixel, reduced to its opaque flag.
  logic s1_v_r, s1_opq_r;
  logic s1_take, out_free;

  // Retire stage state.
  logic [POS_W-1:0] col_r, row_r, col_nxt, row_nxt;
  logic             seen_r, seen_nxt, seen_upd;
  logic             row_end, frame_end;

  // Result register.
  logic              out_v_r;
  logic [RECT_W-1:0] rx_r, ry_r, rw_r, rh_r;
  logic [CMP_W-1:0]  rx_nxt, ry_nxt, rw_nxt, rh_nxt;

  assign row_end   = (CMP_W'(col_r) + CMP_W'(1)) >= w_eff;
  assign frame_end = row_end && ((CMP_W'(row_r) + CMP_W'(1)) >= h_eff);

  // The last pixel of a frame retires only when the result register is free.
  assign out_free     = !out_v_r || out_rect.ready;
  assign s1_take      = s1_v_r && (!frame_end || out_free);
  assign in_pix.ready = !s1_v_r || s1_take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_pix.ready) begin
      s1_v_r <= in_pix.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_pix.valid && in_pix.ready) begin
      s1_opq_r <= in_pix.alpha > thr_r;
    end
  end

  // Extent trackers for the column and row axes.
  atbb_axis_ctl_t   axis_ctl;
  logic [POS_W-1:0] col_lo, col_hi, row_lo, row_hi;

  assign axis_ctl.upd   = s1_take && s1_opq_r;
  assign axis_ctl.first = !seen_r;
  assign axis_ctl.clear = s1_take && frame_end;

  atbb_axis #(.POS_W(POS_W), .LO_RST(POS_LO_RST)) u_col_axis (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (axis_ctl),
    .pos    (col_r),
    .lo_upd (col_lo),
    .hi_upd (col_hi)
  );

  atbb_axis #(.POS_W(POS_W), .LO_RST(POS_LO_RST)) u_row_axis (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (axis_ctl),
    .pos    (row_r),
    .lo_upd (row_lo),
    .hi_upd (row_hi)
  );

  assign seen_upd = seen_r || s1_opq_r;

  always_comb begin
    col_nxt  = col_r;
    row_nxt  = row_r;
    seen_nxt = seen_r;
    if (s1_take) begin
      seen_nxt = seen_upd;
      if (frame_end) begin
        col_nxt  = '0;
        row_nxt  = '0;
        seen_nxt = 1'b0;
      end else if (row_end) begin
        col_nxt = '0;
        row_nxt = row_r + POS_W'(1);
      end else begin
        col_nxt = col_r + POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      seen_r <= 1'b0;
    end else begin
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      seen_r <= seen_nxt;
    end
  end

  // Rectangle from the extents including the frame's last pixel.
  always_comb begin
    if (seen_upd) begin
      rx_nxt = CMP_W'(col_lo);
      ry_nxt = CMP_W'(row_lo);
      rw_nxt = CMP_W'(col_hi) - CMP_W'(col_lo) + CMP_W'(1);
      rh_nxt = CMP_W'(row_hi) - CMP_W'(row_lo) + CMP_W'(1);
    end else begin
      rx_nxt = w_eff;
      ry_nxt = h_eff;
      rw_nxt = '0;
      rh_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (s1_take && frame_end) begin
      out_v_r <= 1'b1;
    end else if (out_rect.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_take && frame_end) begin
      rx_r <= rx_nxt[RECT_W-1:0];
      ry_r <= ry_nxt[RECT_W-1:0];
      rw_r <= rw_nxt[RECT_W-1:0];
      rh_r <= rh_nxt[RECT_W-1:0];
    end
  end

  assign out_rect.valid  = out_v_r;
  assign out_rect.rect_x = rx_r;
  assign out_rect.rect_y = ry_r;
  assign out_rect.rect_w = rw_r;
  assign out_rect.rect_h = rh_r;

  // Closing a frame always leaves the content flag clear and a result pending.
  a_frame_close: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_take && frame_end) |=> (!seen_r && out_v_r))
    else $error("frame close did not restart tracking or post a result");

  // Once content is seen, the stored extents are ordered on both axes.
  a_extent_order: assert property (@(posedge clk) disable iff (!rst_n)
    seen_r |-> (col_lo <= col_hi || axis_ctl.upd) && (row_lo <= row_hi || axis_ctl.upd))
    else $error("extent tracker minimum above maximum");

  // A result register that waits is never overwritten.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && !out_rect.ready) |-> !(s1_take && frame_end))
    else $error("pending rectangle overwritten");

  // An empty rectangle has no width exactly when it has no height.
  a_empty_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> ((rw_r == '0) == (rh_r == '0)))
    else $error("rectangle has one zero side");

endmodule

FILE: hdl/atbb_axis.sv
// Running minimum and maximum of one coordinate over the opaque pixels of a frame.
// Depends on atbb_pkg for the control struct.
module atbb_axis #(
  parameter int unsigned       POS_W  = 12,
  parameter logic [POS_W-1:0]  LO_RST = '1
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  atbb_pkg::atbb_axis_ctl_t        ctl,
  input  logic [POS_W-1:0]                pos,
  output logic [POS_W-1:0]                lo_upd,
  output logic [POS_W-1:0]                hi_upd
);
  import atbb_pkg::*;

  logic [POS_W-1:0] lo_r, hi_r;
  logic [POS_W-1:0] lo_nxt, hi_nxt;

  // Values including the pixel retired this cycle; the result is built from these.
  assign lo_upd = (ctl.upd && (ctl.first || pos < lo_r)) ? pos : lo_r;
  assign hi_upd = (ctl.upd && (ctl.first || pos > hi_r)) ? pos : hi_r;

  always_comb begin
    lo_nxt = lo_upd;
    hi_nxt = hi_upd;
    if (ctl.clear) begin
      lo_nxt = LO_RST;
      hi_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lo_r <= LO_RST;
      hi_r <= '0;
    end else begin
      lo_r <= lo_nxt;
      hi_r <= hi_nxt;
    end
  end

endmodule

FILE: tb/tb_top.sv
// Self-checking testbench for alpha_trim_bounding_box_unit:
// raster alpha words in, trim rectangles out.
// Depends on atbb_pkg, the channel interfaces in atbb_if.sv and the unit's top level.
module tb_top;
  import atbb_pkg::*;

  localparam int unsigned SIDE_MAX     = MAX_SIDE_DEF;
  localparam int unsigned POS_W        = $clog2(SIDE_MAX);
  localparam int unsigned RAND_ITEMS   = 1650;
  localparam int unsigned CALM_ITEMS   = 200;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned CYCLE_LIMIT  = 1000000;
  localparam int unsigned REPORT_MAX   = 10;

  // Index 3 is not a register; writes to it must leave every register alone.
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 2'd3;

  typedef struct packed {
    logic [RECT_W-1:0] x;
    logic [RECT_W-1:0] y;
    logic [RECT_W-1:0] w;
    logic [RECT_W-1:0] h;
  } trim_rect_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  atbb_pix_if  pix_if ();
  atbb_rect_if rect_if ();

  alpha_trim_bounding_box_unit #(.MAX_SIDE(SIDE_MAX)) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_pix    (pix_if),
    .out_rect  (rect_if),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  // Our own copy of the configuration, updated whenever a register is written.
  logic [ALPHA_W-1:0]    thr_m;
  logic [SIDE_CFG_W-1:0] wid_reg;
  logic [SIDE_CFG_W-1:0] hgt_reg;

  // Frame tracking state of the predictor: position of the next pixel and the
  // extents of the opaque pixels seen so far in the current frame.
  logic [POS_W-1:0] col_pos;
  logic [POS_W-1:0] row_pos;
  logic [POS_W-1:0] col_lo;
  logic [POS_W-1:0] col_hi;
  logic [POS_W-1:0] row_lo;
  logic [POS_W-1:0] row_hi;
  bit               opaque_seen;

  logic [ALPHA_W-1:0] pix_q[$];   // pixel words waiting for the driver
  trim_rect_t         trim_q[$];  // rectangles predicted but not yet received

  int unsigned pushed_cnt   = 0;
  int unsigned accepted_cnt = 0;
  int unsigned rects_seen   = 0;
  int unsigned mismatches   = 0;
  int unsigned cycle_cnt    = 0;
  int unsigned hold_asked   = 0;
  int unsigned hold_done    = 0;
  bit          idle_on      = 1'b1;

  // The sizes in force: zero acts as one, anything above the maximum side as the maximum.
  function automatic logic [SIDE_CFG_W-1:0] side_in_force(logic [SIDE_CFG_W-1:0] v);
    if (v == '0) return SIDE_CFG_W'(1);
    if (v > SIDE_CFG_W'(SIDE_MAX)) return SIDE_CFG_W'(SIDE_MAX);
    return v;
  endfunction

  function automatic void restart_frame();
    col_pos     = '0;
    row_pos     = '0;
    col_lo      = POS_W'(SIDE_MAX - 1);
    col_hi      = '0;
    row_lo      = POS_W'(SIDE_MAX - 1);
    row_hi      = '0;
    opaque_seen = 1'b0;
  endfunction

  // Advances the frame state by one accepted pixel and queues the rectangle
  // when that pixel closes the frame.
  function automatic void track_pixel(logic [ALPHA_W-1:0] a);
    logic [SIDE_CFG_W-1:0] w;
    logic [SIDE_CFG_W-1:0] h;
    logic                  row_done;
    logic                  frame_done;
    trim_rect_t            r;
    w = side_in_force(wid_reg);
    h = side_in_force(hgt_reg);
    if (a > thr_m) begin
      if (!opaque_seen || col_pos < col_lo) col_lo = col_pos;
      if (!opaque_seen || col_pos > col_hi) col_hi = col_pos;
      if (!opaque_seen || row_pos < row_lo) row_lo = row_pos;
      if (!opaque_seen || row_pos > row_hi) row_hi = row_pos;
      opaque_seen = 1'b1;
    end
    // The counters are compared against the sizes in force now, so a size
    // shrunk in the middle of a frame closes the row or frame at once.
    row_done   = (SIDE_CFG_W'(col_pos) + 1'b1) >= w;
    frame_done = row_done && ((SIDE_CFG_W'(row_pos) + 1'b1) >= h);
    if (frame_done) begin
      if (opaque_seen) begin
        r.x = RECT_W'(col_lo);
        r.y = RECT_W'(row_lo);
        r.w = RECT_W'(col_hi) - RECT_W'(col_lo) + 1'b1;
        r.h = RECT_W'(row_hi) - RECT_W'(row_lo) + 1'b1;
      end else begin
        // An empty frame reports its own size as the origin and no extent.
        r.x = RECT_W'(w);
        r.y = RECT_W'(h);
        r.w = '0;
        r.h = '0;
      end
      trim_q.push_back(r);
      restart_frame();
    end else if (row_done) begin
      col_pos = '0;
      row_pos = row_pos + 1'b1;
    end else begin
      col_pos = col_pos + 1'b1;
    end
  endfunction

  // Picks an alpha on the requested side of the current threshold. With the
  // threshold at 255 nothing can be opaque, so the brightest value is used.
  function automatic logic [ALPHA_W-1:0] pick_alpha(bit opaque);
    if (!opaque) return ALPHA_W'($urandom_range(0, thr_m));
    if (thr_m == 8'hFF) return 8'hFF;
    return ALPHA_W'($urandom_range(thr_m + 1, 255));
  endfunction

  // Frame sides for random phases: mostly tiny, now and then zero or medium sized.
  function automatic logic [CFG_DATA_W-1:0] pick_side();
    case ($urandom_range(0, 15))
      0:       return '0;
      1:       return CFG_DATA_W'($urandom_range(9, 20));
      default: return CFG_DATA_W'($urandom_range(1, 8));
    endcase
  endfunction

  task automatic push_pixel(logic [ALPHA_W-1:0] a);
    pix_q.push_back(a);
    pushed_cnt++;
  endtask

  // Registers are only written while the unit is idle, so the predictor's copy
  // can change at once.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    case (idx)
      CFG_ALPHA_THRESHOLD: thr_m = data[ALPHA_W-1:0];
      CFG_FRAME_WIDTH:     wid_reg = data;
      CFG_FRAME_HEIGHT:    hgt_reg = data;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Waits until every queued word has been accepted and every predicted
  // rectangle has arrived, then lets the pipeline settle. A partial frame
  // produces nothing, so the settling time covers words still in flight.
  task automatic wait_idle();
    while (accepted_cnt != pushed_cnt) @(posedge clk);
    while (trim_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // One frame at a larger size; opaque pixels only where asked, first and/or last.
  task automatic big_frame(logic [CFG_DATA_W-1:0] w, logic [CFG_DATA_W-1:0] h,
                           bit mark_first, bit mark_last);
    int unsigned n;
    write_reg(CFG_FRAME_WIDTH, w);
    write_reg(CFG_FRAME_HEIGHT, h);
    n = side_in_force(w) * side_in_force(h);
    for (int unsigned i = 0; i < n; i++) begin
      push_pixel(pick_alpha((i == 0 && mark_first) || (i == n - 1 && mark_last)));
    end
    wait_idle();
  endtask

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Global watchdog: a hang anywhere ends the run as a failure.
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d rectangles still expected", cycle_cnt,
               trim_q.size());
      $display("** alpha_trim_bounding_box_unit: FAILED **");
      $finish;
    end
  end

  // Pixel driver. The word on the channel stays put until it is taken; after a
  // word is issued a random gap may follow, so gaps land anywhere in a frame.
  // Every accepted word goes straight into the predictor.
  always @(posedge clk) begin : pix_driver
    int unsigned gap_left;
    if (!rst_n) begin
      pix_if.valid <= 1'b0;
      pix_if.alpha <= '0;
      gap_left = 0;
    end else begin
      if (pix_if.valid && pix_if.ready) begin
        track_pixel(pix_if.alpha);
        accepted_cnt++;
      end
      if (!pix_if.valid || pix_if.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          pix_if.valid <= 1'b0;
        end else if (pix_q.size() != 0) begin
          pix_if.valid <= 1'b1;
          pix_if.alpha <= pix_q.pop_front();
          if (idle_on && $urandom_range(0, 9) == 0) gap_left = $urandom_range(1, 12);
        end else begin
          pix_if.valid <= 1'b0;
        end
      end
    end
  end

  // Rectangle monitor. It checks each accepted word against the oldest
  // prediction and drives ready: random stall bursts, plus a long hold-off
  // whenever the stimulus asks for one, counted out here.
  always @(posedge clk) begin : rect_monitor
    int unsigned stall_left;
    int unsigned hold_left;
    trim_rect_t  want;
    trim_rect_t  got;
    if (!rst_n) begin
      rect_if.ready <= 1'b0;
      stall_left = 0;
      hold_left  = 0;
    end else begin
      if (rect_if.valid && rect_if.ready) begin
        rects_seen++;
        got = '{x: rect_if.rect_x, y: rect_if.rect_y, w: rect_if.rect_w, h: rect_if.rect_h};
        if (trim_q.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_MAX) begin
            $display("Unexpected rectangle word: x=%0d y=%0d w=%0d h=%0d", got.x, got.y,
                     got.w, got.h);
          end
        end else begin
          want = trim_q.pop_front();
          if (got.x !== want.x || got.y !== want.y || got.w !== want.w ||
              got.h !== want.h) begin
            mismatches++;
            if (mismatches <= REPORT_MAX) begin
              $display({"Rectangle %0d wrong: expected x=%0d y=%0d w=%0d h=%0d,",
                        " got x=%0d y=%0d w=%0d h=%0d"},
                       rects_seen, want.x, want.y, want.w, want.h,
                       got.x, got.y, got.w, got.h);
            end
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        rect_if.ready <= 1'b0;
      end else if (hold_done != hold_asked) begin
        hold_done++;
        hold_left = HOLD_CYCLES - 1;
        rect_if.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        rect_if.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 11);
        rect_if.ready <= 1'b0;
      end else begin
        rect_if.ready <= 1'b1;
      end
    end
  end

  // Stimulus: reset, a directed part, then random phases. Each phase ends by
  // waiting for every rectangle, which also pauses the sender until the
  // results are in; registers change only at those points.
  initial begin : stimulus
    int unsigned phases;
    int unsigned rand_base;
    int unsigned done_items;
    int unsigned w_eff;
    int unsigned h_eff;
    int unsigned density;
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_idx       = '0;
    cfg_wdata     = '0;
    phases        = 0;
    thr_m         = THRESH_RST;
    wid_reg       = SIDE_RST;
    hgt_reg       = SIDE_RST;
    restart_frame();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Threshold left at its reset value of zero: only alpha 0 is clear.
    write_reg(CFG_FRAME_WIDTH, 13'd3);
    write_reg(CFG_FRAME_HEIGHT, 13'd2);
    push_pixel(8'd0); push_pixel(8'd0); push_pixel(8'd0);
    push_pixel(8'd0); push_pixel(8'd1); push_pixel(8'd0);
    wait_idle();

    // Alpha equal to the threshold is still clear; one above is opaque.
    write_reg(CFG_ALPHA_THRESHOLD, 13'd254);
    write_reg(CFG_FRAME_WIDTH, 13'd2);
    write_reg(CFG_FRAME_HEIGHT, 13'd2);
    push_pixel(8'd255); push_pixel(8'd254); push_pixel(8'd254); push_pixel(8'd255);
    wait_idle();

    // Threshold 255 (upper data bits dropped) makes every frame empty, and
    // zero sizes act as one, so each pixel is a whole frame.
    write_reg(CFG_ALPHA_THRESHOLD, 13'h1FFF);
    write_reg(CFG_FRAME_WIDTH, 13'd0);
    write_reg(CFG_FRAME_HEIGHT, 13'd0);
    push_pixel(8'd255); push_pixel(8'd0);
    wait_idle();

    // A write to the spare index must change nothing.
    write_reg(CFG_IDX_SPARE, 13'h0AAA);
    write_reg(CFG_ALPHA_THRESHOLD, 13'd127);
    write_reg(CFG_FRAME_WIDTH, 13'd4);
    write_reg(CFG_FRAME_HEIGHT, 13'd1);
    push_pixel(8'd128); push_pixel(8'd127); push_pixel(8'd0); push_pixel(8'd200);
    wait_idle();

    // Width shrunk in the middle of a frame: the column counter is already
    // past the new width, so the row closes on the next pixel.
    write_reg(CFG_FRAME_WIDTH, 13'd4);
    write_reg(CFG_FRAME_HEIGHT, 13'd3);
    push_pixel(8'd0); push_pixel(8'd0); push_pixel(8'd0);
    push_pixel(8'd0); push_pixel(8'd0); push_pixel(8'd200);
    wait_idle();
    write_reg(CFG_FRAME_WIDTH, 13'd2);
    push_pixel(8'd0); push_pixel(8'd0); push_pixel(8'd0);
    wait_idle();

    rand_base  = pushed_cnt;
    done_items = 0;
    while (done_items < RAND_ITEMS) begin
      phases++;
      // Idling is on in most phases, off in some, and off for the closing stretch.
      idle_on = (done_items + CALM_ITEMS < RAND_ITEMS) && ($urandom_range(0, 3) != 0);
      if (phases == 4 || phases == 14) begin
        // Receiver holds off while short frames keep coming, so the unit
        // fills up and stops taking pixels.
        write_reg(CFG_FRAME_WIDTH, (phases == 4) ? 13'd1 : 13'd2);
        write_reg(CFG_FRAME_HEIGHT, 13'd1);
        hold_asked++;
        repeat (40) push_pixel(ALPHA_W'($urandom_range(0, 255)));
      end else if (phases == 9) begin
        // Longer frames. A 1 by 1 setting first closes whatever frame a
        // previous phase left open, so these frames start aligned.
        write_reg(CFG_ALPHA_THRESHOLD, 13'd100);
        write_reg(CFG_FRAME_WIDTH, 13'd1);
        write_reg(CFG_FRAME_HEIGHT, 13'd1);
        push_pixel(pick_alpha(1'b0));
        wait_idle();
        big_frame(13'd64, 13'd1, 1'b0, 1'b0);  // empty, one long row
        big_frame(13'd48, 13'd2, 1'b0, 1'b1);  // only the bottom right pixel
        big_frame(13'd0, 13'd64, 1'b1, 1'b1);  // zero width, full-height extent
        big_frame(13'd1, 13'd40, 1'b0, 1'b0);  // one column, empty
      end else begin
        if ($urandom_range(0, 2) != 0) begin
          case ($urandom_range(0, 5))
            0:       write_reg(CFG_ALPHA_THRESHOLD, '0);
            1:       write_reg(CFG_ALPHA_THRESHOLD, 13'h0FF);
            default: write_reg(CFG_ALPHA_THRESHOLD, CFG_DATA_W'($urandom()));
          endcase
        end
        if ($urandom_range(0, 2) != 0) write_reg(CFG_FRAME_WIDTH, pick_side());
        if ($urandom_range(0, 2) != 0) write_reg(CFG_FRAME_HEIGHT, pick_side());
        if ($urandom_range(0, 9) == 0) write_reg(CFG_IDX_SPARE, CFG_DATA_W'($urandom()));
        w_eff = side_in_force(wid_reg);
        h_eff = side_in_force(hgt_reg);
        repeat ($urandom_range(1, 5)) begin
          // Density in percent of opaque pixels; above 100 means raw noise.
          case ($urandom_range(0, 5))
            0:       density = 0;
            1:       density = 3;
            2:       density = 25;
            3:       density = 70;
            4:       density = 100;
            default: density = 200;
          endcase
          repeat (w_eff * h_eff) begin
            if (density > 100) push_pixel(ALPHA_W'($urandom_range(0, 255)));
            else push_pixel(pick_alpha($urandom_range(1, 100) <= density));
          end
        end
        // Sometimes leave a frame half sent, so the next phase's register
        // writes land in the middle of a frame.
        if ($urandom_range(0, 4) == 0 && w_eff * h_eff > 1) begin
          repeat ($urandom_range(1, w_eff * h_eff - 1)) begin
            push_pixel(ALPHA_W'($urandom_range(0, 255)));
          end
        end
      end
      wait_idle();
      done_items = pushed_cnt - rand_base;
    end

    $display("Run covered %0d pixel words over %0d random phases plus directed frames,",
             pushed_cnt, phases);
    $display("including longer frames and receiver hold-offs; %0d rectangles checked.",
             rects_seen);
    if (mismatches == 0 && trim_q.size() == 0) begin
      $display("** alpha_trim_bounding_box_unit: PASSED **");
    end else begin
      $display("%0d mismatching rectangles, %0d rectangles never arrived", mismatches,
               trim_q.size());
      $display("** alpha_trim_bounding_box_unit: FAILED **");
    end
    $finish;
  end

endmodule

FILE: sim.f
hdl/atbb_pkg.sv
hdl/atbb_if.sv
hdl/atbb_axis.sv
hdl/alpha_trim_bounding_box_unit.sv
tb/tb_top.sv
